// ===== rtl/core/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg
// Shared constants, widths and types for the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int LINE_MAX = 32;
    localparam int ADDR_W   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int LEN_W    = $clog2(LINE_MAX + 1);

    localparam logic [7:0] CHR_ETX   = 8'h03;
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_CARET = 8'h5E;
    localparam logic [7:0] CHR_UC_C  = 8'h43;
    localparam logic [7:0] CHR_TILDE = 8'h7E;
    localparam logic [7:0] CHR_DEL   = 8'h7F;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       last;
    } result_t;

endpackage

// ===== rtl/core/tle_ram.sv =====
// ----------------------------------------------------------------------------
// tle_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/tle_seq.sv =====
// ----------------------------------------------------------------------------
// tle_seq
// Byte decoder and result sequencer; keeps the line length and drives the
// line store ports.
// ----------------------------------------------------------------------------
module tle_seq
    import tle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [7:0]        mem_wdata,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [7:0]        mem_rdata,
    output logic              res_valid,
    output result_t           res,
    input  logic              res_take
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ECHO  = 4'b0010,
        ST_CHARS = 4'b0100,
        ST_FINAL = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        ECHO_PRINT   = 2'd0,
        ECHO_NEWLINE = 2'd1,
        ECHO_ERASE   = 2'd2,
        ECHO_CANCEL  = 2'd3
    } echo_seq_t;

    function automatic logic [1:0] echo_last_pos(input echo_seq_t seq);
        logic [1:0] p;
        case (seq)
            ECHO_PRINT:   p = 2'd0;
            ECHO_NEWLINE: p = 2'd1;
            ECHO_ERASE:   p = 2'd2;
            default:      p = 2'd3;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] echo_char(input echo_seq_t seq, input logic [1:0] pos,
                                             input logic [7:0] held);
        logic [7:0] c;
        c = CHR_NUL;
        case (seq)
            ECHO_PRINT:   c = held;
            ECHO_NEWLINE: c = (pos == 2'd0) ? CHR_CR : CHR_LF;
            ECHO_ERASE:   c = (pos == 2'd1) ? CHR_SPACE : CHR_BS;
            default:
            begin
                case (pos)
                    2'd0:    c = CHR_CARET;
                    2'd1:    c = CHR_UC_C;
                    2'd2:    c = CHR_CR;
                    default: c = CHR_LF;
                endcase
            end
        endcase
        return c;
    endfunction

    state_t      state_reg, state_next;
    echo_seq_t   seq_reg, seq_next;
    logic [1:0]  pos_reg, pos_next;
    logic [7:0]  held_reg, held_next;
    logic        then_chars_reg, then_chars_next;
    logic        then_final_reg, then_final_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic        accept;
    logic        advance;
    logic        echo_done;
    logic        chars_done;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign res_valid = (state_reg != ST_IDLE);
    assign advance   = res_valid && res_take;
    assign echo_done  = (pos_reg == echo_last_pos(seq_reg));
    assign chars_done = (LEN_W'(idx_reg) == count_reg - LEN_W'(1));

    assign mem_waddr = ADDR_W'(len_reg);
    assign mem_wdata = rx_byte;
    assign mem_raddr = idx_next;

    always_comb
    begin
        res.kind     = KIND_ECHO;
        res.out_byte = CHR_NUL;
        res.last     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                res.kind = KIND_ECHO;
            end
            ST_ECHO:
            begin
                res.kind     = KIND_ECHO;
                res.out_byte = echo_char(seq_reg, pos_reg, held_reg);
                res.last     = echo_done && !then_chars_reg && !then_final_reg;
            end
            ST_CHARS:
            begin
                res.kind     = KIND_CHAR;
                res.out_byte = mem_rdata;
            end
            ST_FINAL:
            begin
                res.kind = KIND_END;
                res.last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        seq_next        = seq_reg;
        pos_next        = pos_reg;
        held_next       = held_reg;
        then_chars_next = then_chars_reg;
        then_final_next = then_final_reg;
        len_next        = len_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        mem_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                pos_next = '0;
                if (accept)
                begin
                    unique case (rx_byte) inside
                        CHR_CR, CHR_LF:
                        begin
                            seq_next        = ECHO_NEWLINE;
                            then_chars_next = (len_reg != '0);
                            then_final_next = 1'b1;
                            count_next      = len_reg;
                            len_next        = '0;
                            state_next      = ST_ECHO;
                        end
                        CHR_DEL, CHR_BS:
                        begin
                            if (len_reg != '0)
                            begin
                                seq_next        = ECHO_ERASE;
                                then_chars_next = 1'b0;
                                then_final_next = 1'b0;
                                len_next        = len_reg - LEN_W'(1);
                                state_next      = ST_ECHO;
                            end
                        end
                        CHR_ETX:
                        begin
                            seq_next        = ECHO_CANCEL;
                            then_chars_next = 1'b0;
                            then_final_next = 1'b1;
                            len_next        = '0;
                            state_next      = ST_ECHO;
                        end
                        [CHR_SPACE:CHR_TILDE]:
                        begin
                            if (len_reg < LEN_W'(LINE_MAX))
                            begin
                                mem_we          = 1'b1;
                                held_next       = rx_byte;
                                seq_next        = ECHO_PRINT;
                                then_chars_next = 1'b0;
                                then_final_next = 1'b0;
                                len_next        = len_reg + LEN_W'(1);
                                state_next      = ST_ECHO;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ECHO:
            begin
                if (advance)
                begin
                    if (!echo_done)
                    begin
                        pos_next = pos_reg + 2'd1;
                    end
                    else if (then_chars_reg)
                    begin
                        state_next = ST_CHARS;
                    end
                    else if (then_final_reg)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHARS:
            begin
                if (advance)
                begin
                    if (chars_done)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            ST_FINAL:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            pos_reg        <= '0;
            idx_reg        <= '0;
            count_reg      <= '0;
            then_chars_reg <= 1'b0;
            then_final_reg <= 1'b0;
            seq_reg        <= ECHO_PRINT;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            pos_reg        <= pos_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            then_chars_reg <= then_chars_next;
            then_final_reg <= then_final_next;
            seq_reg        <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(LINE_MAX))
        else $error("line length beyond capacity");

    a_chars_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHARS) |-> (count_reg != '0) && (LEN_W'(idx_reg) < count_reg))
        else $error("line read outside held characters");

    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (rx_byte == CHR_CR || rx_byte == CHR_LF || rx_byte == CHR_ETX)
        |=> (len_reg == '0) && (state_reg == ST_ECHO))
        else $error("line end did not clear the line");

    a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL) && advance |=> (state_reg == ST_IDLE))
        else $error("end marker not followed by idle");

endmodule

// ===== rtl/core/tle_out_stage.sv =====
// ----------------------------------------------------------------------------
// tle_out_stage
// Output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module tle_out_stage
    import tle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    input  result_t    res,
    output logic       res_take,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       last
);

    logic    valid_reg;
    result_t data_reg;

    assign res_take  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign kind      = data_reg.kind;
    assign out_byte  = data_reg.out_byte;
    assign last      = data_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

// ===== rtl/core/terminal_line_editor.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor
// Line editor with echo: printable bytes are stored and echoed, BS/DEL erase,
// Ctrl-C abandons the line, CR/LF streams the completed line.
// The first result of an item passes the sequencer state register and then
// the output register. Throughput: one result per cycle while out_stall is
// low; no new byte is accepted until the sequencer is back in idle, once the
// last result of the item has been taken. Reset clears the line length; store
// contents are undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module terminal_line_editor
    import tle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       last
);

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;
    logic              res_valid;
    result_t           res;
    logic              res_take;

    tle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tle_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    tle_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

// ===== bench/tle_checker.sv =====
// ----------------------------------------------------------------------------
// tle_checker
// Watches both channels of the terminal line editor. Every accepted input
// byte is run through a local line buffer model to queue the echo, line and
// end-marker results it should produce. Every accepted result is compared
// field by field with the oldest queued one. Errors and the number of results
// still outstanding go back to the testbench top.
// ----------------------------------------------------------------------------
module tle_checker
    import tle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] kind,
    input  logic [7:0] out_byte,
    input  logic       last,
    output int         errors,
    output int         pending
);

    logic [7:0] line_chars [LINE_MAX];
    int         line_len;
    result_t    echo_q [$];
    result_t    want;
    int         err_cnt;

    task automatic queue_result(input kind_t k, input logic [7:0] b);
        result_t r;
        r.kind     = k;
        r.out_byte = b;
        r.last     = 1'b0;
        echo_q.push_back(r);
    endtask

    task automatic predict_results(input logic [7:0] b);
        result_t tail;
        int      base;
        base = echo_q.size();
        if (b == CHR_CR || b == CHR_LF)
        begin
            queue_result(KIND_ECHO, CHR_CR);
            queue_result(KIND_ECHO, CHR_LF);
            for (int i = 0; i < line_len; i++)
                queue_result(KIND_CHAR, line_chars[i]);
            queue_result(KIND_END, CHR_NUL);
            line_len = 0;
        end
        else if (b == CHR_DEL || b == CHR_BS)
        begin
            if (line_len > 0)
            begin
                line_len--;
                queue_result(KIND_ECHO, CHR_BS);
                queue_result(KIND_ECHO, CHR_SPACE);
                queue_result(KIND_ECHO, CHR_BS);
            end
        end
        else if (b == CHR_ETX)
        begin
            queue_result(KIND_ECHO, CHR_CARET);
            queue_result(KIND_ECHO, CHR_UC_C);
            queue_result(KIND_ECHO, CHR_CR);
            queue_result(KIND_ECHO, CHR_LF);
            queue_result(KIND_END, CHR_NUL);
            line_len = 0;
        end
        else if (b >= CHR_SPACE && b <= CHR_TILDE && line_len < LINE_MAX)
        begin
            line_chars[line_len] = b;
            line_len++;
            queue_result(KIND_ECHO, b);
        end
        if (echo_q.size() > base)
        begin
            tail      = echo_q[echo_q.size() - 1];
            tail.last = 1'b1;
            echo_q[echo_q.size() - 1] = tail;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len = 0;
            err_cnt  = 0;
            echo_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // results leave only after their item has passed the sequencer and the output
            // register, so the comparison goes before this edge's prediction
            if (out_valid && !out_stall)
            begin
                if (echo_q.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("unexpected result: kind=%0d byte=%02h last=%0b",
                                 kind, out_byte, last);
                    err_cnt++;
                end
                else
                begin
                    want = echo_q.pop_front();
                    if (kind !== want.kind || out_byte !== want.out_byte
                        || last !== want.last)
                    begin
                        if (err_cnt < 10)
                            $display("kind/byte/last exp %0d/%02h/%0b got %0d/%02h/%0b",
                                     want.kind, want.out_byte, want.last,
                                     kind, out_byte, last);
                        err_cnt++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_results(rx_byte);
            errors  <= err_cnt;
            pending <= echo_q.size();
        end
    end

endmodule

// ===== bench/tb_terminal_line_editor.sv =====
// ----------------------------------------------------------------------------
// tb_terminal_line_editor
// Feeds the line editor a directed run of edge bytes (ignored codes, erase
// and completion on an empty line, printable limits, abandon) and then random
// typed lines: printable text with erases, noise bytes, overlong lines and
// CR/LF/Ctrl-C endings. Both sides idle at random; the receiver holds off
// once for a long stretch and the sender pauses once until all results are
// in. Checking is done by tle_checker.
// ----------------------------------------------------------------------------
module tb_terminal_line_editor
    import tle_pkg::*;
;

    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = LINE_MAX + 8;
    localparam int RANDOM_ITEMS = 180;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
    int         errors;
    int         pending;

    logic       hold_req  = 1'b0;
    logic       drain     = 1'b0;
    int         active_sent;

    terminal_line_editor uut (.*);

    tle_checker u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        rx_byte  <= b;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if ((b >= CHR_SPACE && b <= CHR_TILDE)
            || b inside {CHR_CR, CHR_LF, CHR_BS, CHR_DEL, CHR_ETX})
            active_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver
    initial
    begin
        int n;
        logic hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (drain)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                n = gap_len();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                n = ($urandom_range(0, 99) < 5) ? 150 : $urandom_range(1, 12);
                out_stall <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [7:0] directed_bytes [20];
        logic [7:0] b;
        logic       paused;
        int         len;
        int         r;
        directed_bytes = '{CHR_NUL, 8'hFF, 8'h80, 8'h1B, CHR_DEL, CHR_BS, CHR_CR,
                           CHR_LF, CHR_SPACE, CHR_TILDE, 8'h41, CHR_BS, CHR_DEL,
                           8'h78, CHR_LF, 8'h61, 8'h62, CHR_ETX, CHR_ETX, 8'h1F};
        paused = 1'b0;
        active_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        active_sent = 0;
        while (active_sent < RANDOM_ITEMS)
        begin
            if (active_sent > 70 && !hold_req)
                hold_req <= 1'b1;
            if (active_sent > 150 && !paused)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            len = ($urandom_range(0, 99) < 10) ? $urandom_range(LINE_MAX - 2, LINE_MAX + 4)
                                               : $urandom_range(0, 10);
            repeat (len)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    b = 8'($urandom_range(CHR_SPACE, CHR_TILDE));
                else if (r < 88)
                    b = $urandom_range(0, 1) ? CHR_BS : CHR_DEL;
                else
                    b = 8'($urandom_range(0, 255));
                send_byte(b);
            end
            r = $urandom_range(0, 99);
            if (r < 45)
                send_byte(CHR_CR);
            else if (r < 80)
                send_byte(CHR_LF);
            else if (r < 92)
                send_byte(CHR_ETX);
        end

        in_valid <= 1'b0;
        drain    <= 1'b1;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tle_pkg.sv
rtl/core/tle_ram.sv
rtl/core/tle_seq.sv
rtl/core/tle_out_stage.sv
rtl/core/terminal_line_editor.sv
bench/tle_checker.sv
bench/tb_terminal_line_editor.sv
